// ===== sv/erot_pkg.sv =====
// Shared types and constants for the Euler rotation transform packer.
// Used by every module of the block; depends on nothing.

package erot_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int DIV_BITS       = 31;
    localparam int IN_BITS        = 240;
    localparam int OUT_BITS       = 128;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;
    localparam logic [1:0]         LAST_GROUP  = 2'd3;

    localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] scale_z;
        logic [31:0] scale_y;
        logic [31:0] scale_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [15:0] angle_z;
        logic [15:0] angle_y;
        logic [15:0] angle_x;
    } t_in;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               flip;
    } t_rot;

    typedef struct packed {
        logic [31:0]         s;
        logic [31:0]         rem;
        logic [DIV_BITS-1:0] q;
        logic                sat;
    } t_div;

    typedef struct packed {
        t_rot [2:0]        rot;
        t_div [2:0]        dv;
        logic [2:0][31:0]  pos;
    } t_fst;

    // Sixteen entries, indexed by group and then by entry, entry a lowest.
    typedef struct packed {
        logic [3:0][3:0][31:0] e;
    } t_mat;

endpackage

// ===== sv/erot_front.sv =====
// Front pipeline: angle folding, one CORDIC step per stage (all stages but the last)
// for three angles, and one quotient bit per stage of three reciprocal divisions.
// Depends on erot_pkg.

module erot_front #(
    parameter int ANGLE_BITS = erot_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = erot_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  erot_pkg::t_in    i_item,
    output logic             o_valid,
    output erot_pkg::t_fst   o_st
);

    localparam int          NST      = erot_pkg::DIV_BITS;
    localparam int          DIV_TOP  = 2 * FRAC_BITS;
    localparam int          REM_SH   = (DIV_TOP >= NST) ? DIV_TOP - NST : 0;
    localparam logic [31:0] SAT_LIM  = (DIV_TOP >= NST) ? 32'(64'd1 << REM_SH) : 32'd0;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    erot_pkg::t_fst c_in;
    erot_pkg::t_fst n_st [0:NST-1];
    erot_pkg::t_fst r_st [0:NST-1];
    logic [NST-1:0] r_vld;

    function automatic erot_pkg::t_fst f_step(input erot_pkg::t_fst p, input int j);
        erot_pkg::t_fst     n;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [32:0]        tr;
        n = p;
        for (int k = 0; k < 3; k++) begin
            if (j < erot_pkg::CORDIC_STEPS) begin
                dx = $signed(p.rot[k].y) >>> j;
                dy = $signed(p.rot[k].x) >>> j;
                if (!p.rot[k].z[31]) begin
                    n.rot[k].x = p.rot[k].x - dx;
                    n.rot[k].y = p.rot[k].y + dy;
                    n.rot[k].z = p.rot[k].z - $signed(erot_pkg::ATAN_TURN[j]);
                end else begin
                    n.rot[k].x = p.rot[k].x + dx;
                    n.rot[k].y = p.rot[k].y - dy;
                    n.rot[k].z = p.rot[k].z + $signed(erot_pkg::ATAN_TURN[j]);
                end
            end
            tr = {p.dv[k].rem, ((NST - 1 - j) == DIV_TOP)};
            if (tr >= {1'b0, p.dv[k].s}) begin
                n.dv[k].rem = 32'(tr - {1'b0, p.dv[k].s});
                n.dv[k].q[NST-1-j] = 1'b1;
            end else begin
                n.dv[k].rem = tr[31:0];
            end
        end
        return n;
    endfunction

    always_comb begin
        logic [2:0][15:0] ang;
        logic [2:0][31:0] scl;
        logic [31:0]      t;
        logic [31:0]      tp;
        ang = {i_item.angle_z, i_item.angle_y, i_item.angle_x};
        scl = {i_item.scale_z, i_item.scale_y, i_item.scale_x};
        c_in = '0;
        c_in.pos = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
        for (int k = 0; k < 3; k++) begin
            t  = (32'(ang[k]) & ANG_MASK) << (32 - ANGLE_BITS);
            tp = t + 32'h4000_0000;
            c_in.rot[k].flip = tp[31];
            c_in.rot[k].z    = tp[31] ? t + 32'h8000_0000 : t;
            c_in.rot[k].x    = erot_pkg::CORDIC_GAIN;
            c_in.rot[k].y    = '0;
            c_in.dv[k].s     = scl[k];
            c_in.dv[k].rem   = SAT_LIM;
            c_in.dv[k].q     = '0;
            c_in.dv[k].sat   = (scl[k] <= SAT_LIM);
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_st
        if (j == 0) begin : g_first
            assign n_st[j] = f_step(c_in, j);
        end else begin : g_rest
            assign n_st[j] = f_step(r_st[j-1], j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NST; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_st    = r_st[NST-1];

endmodule

// ===== sv/erot_matrix.sv =====
// Matrix pipeline: rounding of sines and cosines, two product stages and the
// final sums, giving all sixteen entries of the transform.
// Depends on erot_pkg.

module erot_matrix #(
    parameter int FRAC_BITS = erot_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  erot_pkg::t_fst  i_st,
    output logic            o_valid,
    output erot_pkg::t_mat  o_mat
);

    localparam int W     = FRAC_BITS + 2;
    localparam int RSH   = 30 - FRAC_BITS;
    localparam int RND_C = 1 << (RSH - 1);
    localparam int RND_M = 1 << (FRAC_BITS - 1);

    logic [3:0] r_vld;

    logic signed [W-1:0] r_s [3];
    logic signed [W-1:0] r_c [3];
    logic [31:0]         r_npos0 [3];
    logic [31:0]         r_rcp0 [3];

    logic signed [W-1:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_sxsz;
    logic signed [W-1:0] r_cxsz, r_cxcz, r_sxcz, r_sxcy, r_cxcy, r_sy1;
    logic [31:0]         r_npos1 [3];
    logic [31:0]         r_rcp1 [3];

    // The cosine and sine of angle_z are carried beside the first products so
    // that the triple products can use them.
    logic signed [W-1:0] r_cz1, r_sz1;

    logic signed [W-1:0] r_t0, r_t1, r_t2, r_t3;
    logic signed [W-1:0] r_cycz2, r_cysz2, r_sxsz2, r_cxsz2, r_cxcz2;
    logic signed [W-1:0] r_sxcz2, r_sxcy2, r_cxcy2, r_sy2;
    logic [31:0]         r_npos2 [3];
    logic [31:0]         r_rcp2 [3];

    erot_pkg::t_mat r_mat;

    function automatic logic signed [W-1:0] f_frac(input logic signed [31:0] v);
        logic signed [32:0] sm;
        sm = 33'(v) + 33'(RND_C);
        return W'(sm >>> RSH);
    endfunction

    function automatic logic signed [W-1:0] f_mul(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [2*W-1:0] pr;
        pr = a * b;
        pr = pr + (2*W)'(RND_M);
        return W'(pr >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] f_sum(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b,
                                          input logic                sub);
        logic signed [W:0] sm;
        sm = sub ? (W+1)'(a) - (W+1)'(b) : (W+1)'(a) + (W+1)'(b);
        return 32'(sm);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= f_frac(i_st.rot[k].flip ? -i_st.rot[k].y : i_st.rot[k].y);
                r_c[k] <= f_frac(i_st.rot[k].flip ? -i_st.rot[k].x : i_st.rot[k].x);
                r_npos0[k] <= (i_st.pos[k] == 32'h8000_0000) ? 32'h7FFF_FFFF
                                                              : 32'd0 - i_st.pos[k];
                r_rcp0[k] <= i_st.dv[k].sat ? 32'h7FFF_FFFF : {1'b0, i_st.dv[k].q};
            end

            r_sxsy  <= f_mul(r_s[0], r_s[1]);
            r_cxsy  <= f_mul(r_c[0], r_s[1]);
            r_cycz  <= f_mul(r_c[1], r_c[2]);
            r_cysz  <= f_mul(r_c[1], r_s[2]);
            r_sxsz  <= f_mul(r_s[0], r_s[2]);
            r_cxsz  <= f_mul(r_c[0], r_s[2]);
            r_cxcz  <= f_mul(r_c[0], r_c[2]);
            r_sxcz  <= f_mul(r_s[0], r_c[2]);
            r_sxcy  <= f_mul(r_s[0], r_c[1]);
            r_cxcy  <= f_mul(r_c[0], r_c[1]);
            r_sy1   <= r_s[1];
            r_npos1 <= r_npos0;
            r_rcp1  <= r_rcp0;

            r_t0    <= f_mul(r_sxsy, r_cz1);
            r_cycz2 <= r_cycz;
            r_cysz2 <= r_cysz;
            r_sxsz2 <= r_sxsz;
            r_cxsz2 <= r_cxsz;
            r_cxcz2 <= r_cxcz;
            r_sxcz2 <= r_sxcz;
            r_sxcy2 <= r_sxcy;
            r_cxcy2 <= r_cxcy;
            r_sy2   <= r_sy1;
            r_npos2 <= r_npos1;
            r_rcp2  <= r_rcp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cz1 <= r_c[2];
            r_sz1 <= r_s[2];
            r_t1  <= f_mul(r_sxsy, r_sz1);
            r_t2  <= f_mul(r_cxsy, r_cz1);
            r_t3  <= f_mul(r_cxsy, r_sz1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat.e[0][0] <= 32'(r_cycz2);
            r_mat.e[0][1] <= f_sum(r_t0, r_cxsz2, 1'b1);
            r_mat.e[0][2] <= f_sum(r_t2, r_sxsz2, 1'b0);
            r_mat.e[0][3] <= r_npos2[0];
            r_mat.e[1][0] <= 32'(r_cysz2);
            r_mat.e[1][1] <= f_sum(r_t1, r_cxcz2, 1'b0);
            r_mat.e[1][2] <= f_sum(r_t3, r_sxcz2, 1'b1);
            r_mat.e[1][3] <= r_npos2[1];
            r_mat.e[2][0] <= f_sum('0, r_sy2, 1'b1);
            r_mat.e[2][1] <= 32'(r_sxcy2);
            r_mat.e[2][2] <= 32'(r_cxcy2);
            r_mat.e[2][3] <= r_npos2[2];
            r_mat.e[3][0] <= r_rcp2[0];
            r_mat.e[3][1] <= r_rcp2[1];
            r_mat.e[3][2] <= r_rcp2[2];
            r_mat.e[3][3] <= 32'(64'd1 << FRAC_BITS);
        end
    end

    assign o_valid = r_vld[3];
    assign o_mat   = r_mat;

endmodule

// ===== sv/erot_serial.sv =====
// Output stage: holds one finished transform and sends it as four items,
// one group per item, flagging the last.
// Depends on erot_pkg.

module erot_serial (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  erot_pkg::t_mat                  i_mat,
    output logic                            o_ready,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [erot_pkg::OUT_BITS-1:0]   o_tdata,
    output logic [1:0]                      o_tuser,
    output logic                            o_tlast
);

    logic           r_busy;
    logic [1:0]     r_grp;
    erot_pkg::t_mat r_mat;

    assign o_ready  = !r_busy || (i_tready && r_grp == erot_pkg::LAST_GROUP);
    assign o_tvalid = r_busy;
    assign o_tdata  = r_mat.e[r_grp];
    assign o_tuser  = r_grp;
    assign o_tlast  = (r_grp == erot_pkg::LAST_GROUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (r_busy && i_tready) begin
            if (r_grp == erot_pkg::LAST_GROUP) begin
                r_busy <= 1'b0;
            end
            r_grp <= r_grp + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat <= i_mat;
        end
    end

`ifndef NO_ASSERTIONS
    a_grp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_tready && r_grp != erot_pkg::LAST_GROUP
        |=> r_busy && r_grp == 2'($past(r_grp) + 2'd1))
        else $error("group index did not advance by one");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && i_tready && o_tlast && !i_load |=> !o_tvalid)
        else $error("output still valid after the last group");

    a_idle_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_grp == 2'd0)
        else $error("group index not zero while idle");
`endif

endmodule

// ===== sv/euler_rotation_transform_pack.sv =====
// Top level of the Euler rotation transform packer: front pipeline, matrix
// pipeline and output stage. Depends on erot_pkg, erot_front, erot_matrix
// and erot_serial.
//
//   channel   direction  tdata                                   tuser        tlast
//   s_axis    in         angles x,y,z, pos x,y,z, scales x,y,z   -            -
//   m_axis    out        entries a,b,c,d                         group_index  is_last
//
// An accepted item passes 31 front stages (one quotient bit each, and one CORDIC
// step in each but the last), 4 matrix stages and the output register before
// its first result can be taken.
// Each item gives four results, sent one group at a time, so the output stage
// takes a new item only when idle or as the last group of the one before is taken.
// Reset is synchronous; it clears all valid bits and the output group and busy flag.
// While a finished transform waits for the output stage, the whole pipeline
// halts; nothing is lost or repeated.

module euler_rotation_transform_pack #(
    parameter int ANGLE_BITS = erot_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = erot_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // angle_x, angle_y, angle_z, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z
    input  logic [erot_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // entry_a, entry_b, entry_c, entry_d
    output logic [erot_pkg::OUT_BITS-1:0]  m_axis_tdata,
    // group_index
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic           w_en;
    logic           w_ser_ready;
    logic           w_front_vld;
    logic           w_mat_vld;
    erot_pkg::t_fst w_front_st;
    erot_pkg::t_mat w_mat;

    assign w_en          = !w_mat_vld || w_ser_ready;
    assign s_axis_tready = w_en;

    erot_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_item  (erot_pkg::t_in'(s_axis_tdata)),
        .o_valid (w_front_vld),
        .o_st    (w_front_st)
    );

    erot_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_vld),
        .i_st    (w_front_st),
        .o_valid (w_mat_vld),
        .o_mat   (w_mat)
    );

    erot_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_mat_vld && w_ser_ready),
        .i_mat    (w_mat),
        .o_ready  (w_ser_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/tb.sv =====
// Testbench for euler_rotation_transform_pack: drives object transforms and
// checks every matrix group against an in-bench fixed-point predictor.
// Depends on erot_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam int ABITS = 16;
    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM = 280;
    localparam int IN_W = erot_pkg::IN_BITS;

    typedef struct packed {
        logic [1:0]  grp;
        logic [31:0] ea, eb, ec, ed;
        logic        last;
    } t_group;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [erot_pkg::IN_BITS-1:0]  s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [erot_pkg::OUT_BITS-1:0] m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          m_axis_tlast;

    t_group expected_groups[$];
    int     errors = 0;
    bit     feeding_done = 0;
    erot_pkg::t_in table_in[N_DIRECTED];
    logic [31:0] table_recip[N_DIRECTED][3];
    logic [31:0] table_negpos[N_DIRECTED][3];
    bit     table_known[N_DIRECTED];

    euler_rotation_transform_pack uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic longint fshift(longint v, int n);
        if (v >= 0) return v >>> n;
        return ~((~v) >>> n);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return fshift(a * b + (64'sd1 <<< (FRAC - 1)), FRAC);
    endfunction

    task automatic sine_cosine(input logic [15:0] ang, output longint s, output longint c);
        logic [31:0] turn;
        bit     flip;
        longint x, y, z, dx, dy;
        turn = {ang[ABITS-1:0], {(32-ABITS){1'b0}}};
        flip = ((turn + 32'h40000000) & 32'h80000000) != 0;
        if (flip) turn = turn + 32'h80000000;
        x = erot_pkg::CORDIC_GAIN;
        y = 0;
        z = longint'(signed'(turn));
        for (int i = 0; i < erot_pkg::CORDIC_STEPS; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(erot_pkg::ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(erot_pkg::ATAN_TURN[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        s = fshift(y + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
        c = fshift(x + (64'sd1 <<< (29 - FRAC)), 30 - FRAC);
    endtask

    function automatic logic [31:0] negate_position(logic [31:0] p);
        return 32'(clamp32(-longint'(signed'(p))));
    endfunction

    function automatic logic [31:0] reciprocal_scale(logic [31:0] sc);
        longint q;
        if (sc == 0) return 32'h7FFFFFFF;
        q = (64'sd1 <<< (2 * FRAC)) / longint'({32'b0, sc});
        if (q > 64'sd2147483647) return 32'h7FFFFFFF;
        return 32'(q);
    endfunction

    task automatic predict_transform(input erot_pkg::t_in it);
        longint sx, cx, sy, cy, sz, cz;
        longint m[3][3];
        logic [31:0] np[3];
        t_group gr;
        sine_cosine(it.angle_x, sx, cx);
        sine_cosine(it.angle_y, sy, cy);
        sine_cosine(it.angle_z, sz, cz);
        m[0][0] = qmul(cy, cz);
        m[0][1] = qmul(qmul(sx, sy), cz) - qmul(cx, sz);
        m[0][2] = qmul(qmul(cx, sy), cz) + qmul(sx, sz);
        m[1][0] = qmul(cy, sz);
        m[1][1] = qmul(qmul(sx, sy), sz) + qmul(cx, cz);
        m[1][2] = qmul(qmul(cx, sy), sz) - qmul(sx, cz);
        m[2][0] = -sy;
        m[2][1] = qmul(sx, cy);
        m[2][2] = qmul(cx, cy);
        np[0] = negate_position(it.pos_x);
        np[1] = negate_position(it.pos_y);
        np[2] = negate_position(it.pos_z);
        for (int g = 0; g < 3; g++) begin
            gr = '{2'(g), 32'(clamp32(m[g][0])), 32'(clamp32(m[g][1])),
                   32'(clamp32(m[g][2])), np[g], 1'b0};
            expected_groups = {expected_groups, gr};
        end
        gr = '{erot_pkg::LAST_GROUP, reciprocal_scale(it.scale_x),
               reciprocal_scale(it.scale_y), reciprocal_scale(it.scale_z),
               32'sd1 <<< FRAC, 1'b1};
        expected_groups = {expected_groups, gr};
    endtask

    task automatic set_row(input int k, input erot_pkg::t_in it, input bit known,
                           input logic [31:0] r0, r1, r2, n0, n1, n2);
        table_in[k] = it;
        table_known[k] = known;
        table_recip[k] = '{r0, r1, r2};
        table_negpos[k] = '{n0, n1, n2};
    endtask

    task automatic send_item(input erot_pkg::t_in it);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_transform(it);
    endtask

    function automatic erot_pkg::t_in random_item();
        erot_pkg::t_in it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
        case ($urandom_range(0, 5))
            0: it.scale_x = $urandom_range(0, 3);
            1: it.scale_y = 32'h00010000 >> $urandom_range(0, 16);
            2: it.scale_z = $urandom_range(0, 32'h00030000);
            3: it.pos_x = 32'h80000000;
            4: it.angle_y = 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
            default: ;
        endcase
        return it;
    endfunction

    initial begin
        erot_pkg::t_in it;
        int base;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        set_row(0, '{default: '0}, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0);
        it = '{default: '1};
        set_row(1, it, 1, 1, 1, 1, 1, 1, 1);
        it = '0;
        it.pos_x = 32'h80000000; it.pos_y = 32'h7FFFFFFF; it.pos_z = 32'h00010000;
        it.scale_x = 32'h00010000; it.scale_y = 32'h00000001; it.scale_z = 32'h00000002;
        set_row(2, it, 1, 32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000001, 32'hFFFF0000);
        it.scale_x = 32'h00000003; it.scale_y = 32'h00020000; it.scale_z = 32'h80000000;
        set_row(3, it, 1, 32'h55555555, 32'h00008000, 32'h00000002,
                32'h7FFFFFFF, 32'h80000001, 32'hFFFF0000);
        for (int k = 4; k < N_DIRECTED; k++) begin
            it = '0;
            it.angle_x = 16'(16'h2000 * (k - 4));
            it.angle_y = 16'(16'h4000 * (k % 4) + (k > 9 ? 16'hFFFF : 16'h0));
            it.angle_z = 16'(16'hC000 + 16'h1555 * k);
            it.scale_x = 32'h00010000; it.scale_y = 32'h00010000; it.scale_z = 32'h00010000;
            set_row(k, it, 0, 0, 0, 0, 0, 0, 0);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIRECTED; k++) begin
            base = expected_groups.size();
            send_item(table_in[k]);
            if (table_known[k]) begin
                for (int g = 0; g < 3; g++) begin
                    expected_groups[base + g].ed = table_negpos[k][g];
                end
                expected_groups[base + 3].ea = table_recip[k][0];
                expected_groups[base + 3].eb = table_recip[k][1];
                expected_groups[base + 3].ec = table_recip[k][2];
            end
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            send_item(random_item());
        end
        s_axis_tvalid <= 1'b0;
        feeding_done = 1;
    end

    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (m_axis_tready && m_axis_tvalid) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        t_group got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                    m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tlast};
            if (expected_groups.size() == 0) begin
                $display("%0t unexpected group: actual %h", $time, got);
                errors++;
            end else begin
                want = expected_groups.pop_front();
                if (got !== want) begin
                    $display("%0t group mismatch: expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (feeding_done);
        while (expected_groups.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
